// ===== rtl/core/fbpr_pkg.sv =====
// shared types and constants of the frame buffer pixel and rectangle engine
package fbpr_pkg;

	// command codes on the func field
	localparam logic [2:0] FUNC_SET     = 3'd0;
	localparam logic [2:0] FUNC_GET     = 3'd1;
	localparam logic [2:0] FUNC_OUTLINE = 3'd2;
	localparam logic [2:0] FUNC_FILL    = 3'd3;
	localparam logic [2:0] FUNC_CLEAR   = 3'd4;

	// configuration register indexes
	localparam logic [1:0] REG_PIXEL_MODE = 2'd0;
	localparam logic [1:0] REG_COLUMNS    = 2'd1;
	localparam logic [1:0] REG_ROWS       = 2'd2;

	// configuration reset values
	localparam logic       MODE_RESET = 1'b0;
	localparam logic [7:0] COLS_RESET = 8'd128;
	localparam logic [6:0] ROWS_RESET = 7'd64;

	// entries of the command queue between front and back
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [2:0] {
		OP_SET,
		OP_GET,
		OP_OUTLINE,
		OP_FILL,
		OP_CLEAR,
		OP_NOP
	} op_t;

	// classified command as it travels through the queue
	typedef struct packed {
		op_t         op;
		logic [7:0]  x1;
		logic [7:0]  y1;
		logic [7:0]  x2;
		logic [7:0]  y2;
		logic [15:0] color;
		logic        h_ok;
		logic        v_ok;
		logic        fill_ok;
	} cmd_t;

	// effective frame geometry
	typedef struct packed {
		logic       rgb;
		logic [7:0] cols;
		logic [6:0] rows;
		logic [7:0] wpr;
	} geom_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_PLOT,
		ST_MODIFY,
		ST_CLEAR,
		ST_DONE
	} bstate_t;

	typedef enum logic [1:0] {
		PH_HORZ,
		PH_VERT,
		PH_FILL
	} phase_t;

endpackage

// ===== rtl/core/fbpr_front.sv =====
// front end: accepts commands, classifies them and hands them to the queue
module fbpr_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             hold,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [2:0]       func,
	input  logic [7:0]       x_first,
	input  logic [7:0]       y_first,
	input  logic [7:0]       x_second,
	input  logic [7:0]       y_second,
	input  logic [15:0]      pen_color,
	input  logic             q_ready,
	output logic             q_push,
	output fbpr_pkg::cmd_t   q_cmd
);
	import fbpr_pkg::*;

	cmd_t dec;
	cmd_t cmd_s1;
	logic valid_s1;
	logic accept;

	// decode func and precompute the rectangle loop conditions
	always_comb begin
		dec = '0;
		case (func)
			FUNC_SET:     dec.op = OP_SET;
			FUNC_GET:     dec.op = OP_GET;
			FUNC_OUTLINE: dec.op = OP_OUTLINE;
			FUNC_FILL:    dec.op = OP_FILL;
			FUNC_CLEAR:   dec.op = OP_CLEAR;
			default:      dec.op = OP_NOP;
		endcase
		dec.x1      = x_first;
		dec.y1      = y_first;
		dec.x2      = x_second;
		dec.y2      = y_second;
		dec.color   = pen_color;
		dec.h_ok    = x_first <= x_second;
		dec.v_ok    = y_first <= y_second;
		dec.fill_ok = ({1'b0, x_first} + 9'd1 < {1'b0, x_second}) &&
			({1'b0, y_first} + 9'd1 < {1'b0, y_second});
	end

	// one holding stage ahead of the queue
	assign q_push   = valid_s1 && q_ready;
	assign q_cmd    = cmd_s1;
	assign in_stall = hold || (valid_s1 && !q_ready);
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= dec;
		end
	end

endmodule

// ===== rtl/core/fbpr_cmd_queue.sv =====
// short command queue decoupling the front end from the drawing back end
module fbpr_cmd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  fbpr_pkg::cmd_t push_cmd,
	output logic           push_ready,
	input  logic           pop,
	output fbpr_pkg::cmd_t head_cmd,
	output logic           head_valid
);
	import fbpr_pkg::*;

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	cmd_t          slot_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   count_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = count_q != (PW+1)'(QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head_cmd   = slot_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && head_valid;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// slot storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// ===== rtl/core/fbpr_back.sv =====
// back end: pixel walker, frame store read-modify-write and result register
module fbpr_back #(
	parameter int MAX_COLS = 128,
	parameter int MAX_ROWS = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  fbpr_pkg::geom_t geom,
	input  logic            head_valid,
	input  fbpr_pkg::cmd_t  head_cmd,
	output logic            pop,
	output logic            init_busy,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [15:0]     pixel_value,
	output logic            out_of_range
);
	import fbpr_pkg::*;

	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW    = $clog2(DEPTH);

	logic [15:0]   store_q [DEPTH];
	logic [15:0]   rdata_q;

	bstate_t       state_q, state_d;
	phase_t        ph_q, ph_d;
	logic          sub_q, sub_d;
	logic [7:0]    cx_q, cx_d;
	logic [7:0]    cy_q, cy_d;
	cmd_t          cmd_q, cmd_d;
	logic [AW-1:0] init_q, init_d;
	logic [AW-1:0] wr_addr_q, wr_addr_d;
	logic [3:0]    bit_q, bit_d;
	logic [15:0]   value_q, value_d;
	logic          oor_q, oor_d;

	logic          out_valid_q;
	logic [15:0]   pixel_value_q;
	logic          out_of_range_q;
	logic          out_load;

	logic [7:0]    px, py;
	logic [3:0]    q_idx;
	logic          in_frame;
	logic [7:0]    word;
	logic [7:0]    arow, aword;
	logic [AW-1:0] addr;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [15:0]   mem_wdata;
	logic [15:0]   mask;
	logic [15:0]   mod_data;
	logic [15:0]   get_data;

	phase_t        adv_ph;
	logic          adv_sub;
	logic [7:0]    adv_cx, adv_cy;
	logic          adv_last;

	// pixel under the walker
	always_comb begin
		px = cx_q;
		py = cy_q;
		case (ph_q)
			PH_HORZ: py = sub_q ? cmd_q.y2 : cmd_q.y1;
			PH_VERT: px = sub_q ? cmd_q.x2 : cmd_q.x1;
			default: ;
		endcase
		if (cmd_q.op == OP_SET || cmd_q.op == OP_GET) begin
			px = cmd_q.x1;
			py = cmd_q.y1;
		end
	end

	// locate the pixel: frame check and word within the row
	always_comb begin
		q_idx    = px[7:4];
		in_frame = (px < geom.cols) && (py < {1'b0, geom.rows}) &&
			(geom.rgb || ({4'd0, q_idx} < geom.wpr));
		word     = geom.rgb ? px : geom.wpr - 8'd1 - {4'd0, q_idx};
	end

	// store address: row base plus word, shared by plotting and clearing
	always_comb begin
		arow  = (state_q == ST_CLEAR) ? cy_q : py;
		aword = (state_q == ST_CLEAR) ? cx_q : word;
		addr  = AW'(AW'(arow) * AW'(MAX_COLS)) + AW'(aword);
	end

	// modified word for a pixel write, and the value of a pixel read
	always_comb begin
		mask = 16'd1 << bit_q;
		if (geom.rgb) begin
			mod_data = cmd_q.color;
			get_data = rdata_q;
		end else begin
			mod_data = (cmd_q.color != '0) ? (rdata_q | mask) : (rdata_q & ~mask);
			get_data = {15'd0, rdata_q[bit_q]};
		end
	end

	// walker advance after one pixel
	always_comb begin
		adv_ph   = ph_q;
		adv_sub  = sub_q;
		adv_cx   = cx_q;
		adv_cy   = cy_q;
		adv_last = 1'b0;
		if (cmd_q.op == OP_SET || cmd_q.op == OP_GET) begin
			adv_last = 1'b1;
		end else begin
			case (ph_q)
				PH_HORZ: begin
					if (!sub_q) begin
						adv_sub = 1'b1;
					end else begin
						adv_sub = 1'b0;
						if (cx_q == cmd_q.x2) begin
							if (cmd_q.v_ok) begin
								adv_ph = PH_VERT;
								adv_cy = cmd_q.y1;
							end else begin
								adv_last = 1'b1;
							end
						end else begin
							adv_cx = cx_q + 8'd1;
						end
					end
				end
				PH_VERT: begin
					if (!sub_q) begin
						adv_sub = 1'b1;
					end else begin
						adv_sub = 1'b0;
						if (cy_q == cmd_q.y2) begin
							if (cmd_q.op == OP_FILL && cmd_q.fill_ok) begin
								adv_ph = PH_FILL;
								adv_cx = cmd_q.x1 + 8'd1;
								adv_cy = cmd_q.y1 + 8'd1;
							end else begin
								adv_last = 1'b1;
							end
						end else begin
							adv_cy = cy_q + 8'd1;
						end
					end
				end
				PH_FILL: begin
					if (cy_q == cmd_q.y2 - 8'd1) begin
						if (cx_q == cmd_q.x2 - 8'd1) begin
							adv_last = 1'b1;
						end else begin
							adv_cx = cx_q + 8'd1;
							adv_cy = cmd_q.y1 + 8'd1;
						end
					end else begin
						adv_cy = cy_q + 8'd1;
					end
				end
				default: adv_last = 1'b1;
			endcase
		end
	end

	// sequencer: next state, store writes and queue pop
	always_comb begin
		state_d   = state_q;
		ph_d      = ph_q;
		sub_d     = sub_q;
		cx_d      = cx_q;
		cy_d      = cy_q;
		cmd_d     = cmd_q;
		init_d    = init_q;
		wr_addr_d = wr_addr_q;
		bit_d     = bit_q;
		value_d   = value_q;
		oor_d     = oor_q;
		pop       = 1'b0;
		out_load  = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = addr;
		mem_wdata = '0;
		case (state_q)
			ST_INIT: begin
				mem_we    = 1'b1;
				mem_waddr = init_q;
				if (init_q == AW'(DEPTH - 1)) begin
					state_d = ST_IDLE;
				end else begin
					init_d = init_q + 1'b1;
				end
			end
			ST_IDLE: begin
				if (head_valid) begin
					pop     = 1'b1;
					cmd_d   = head_cmd;
					value_d = '0;
					oor_d   = 1'b0;
					sub_d   = 1'b0;
					case (head_cmd.op)
						OP_SET, OP_GET: state_d = ST_PLOT;
						OP_OUTLINE, OP_FILL: begin
							if (head_cmd.h_ok) begin
								ph_d    = PH_HORZ;
								cx_d    = head_cmd.x1;
								state_d = ST_PLOT;
							end else if (head_cmd.v_ok) begin
								ph_d    = PH_VERT;
								cy_d    = head_cmd.y1;
								state_d = ST_PLOT;
							end else begin
								state_d = ST_DONE;
							end
						end
						OP_CLEAR: begin
							cx_d    = '0;
							cy_d    = '0;
							state_d = ST_CLEAR;
						end
						default: state_d = ST_DONE;
					endcase
				end
			end
			ST_PLOT: begin
				if (in_frame) begin
					wr_addr_d = addr;
					bit_d     = ~px[3:0];
					state_d   = ST_MODIFY;
				end else begin
					if (cmd_q.op == OP_GET) begin
						oor_d = 1'b1;
					end
					ph_d  = adv_ph;
					sub_d = adv_sub;
					cx_d  = adv_cx;
					cy_d  = adv_cy;
					if (adv_last) begin
						state_d = ST_DONE;
					end
				end
			end
			ST_MODIFY: begin
				if (cmd_q.op == OP_GET) begin
					value_d = get_data;
				end else begin
					mem_we    = 1'b1;
					mem_waddr = wr_addr_q;
					mem_wdata = mod_data;
				end
				ph_d    = adv_ph;
				sub_d   = adv_sub;
				cx_d    = adv_cx;
				cy_d    = adv_cy;
				state_d = adv_last ? ST_DONE : ST_PLOT;
			end
			ST_CLEAR: begin
				mem_we = 1'b1;
				if (cx_q == geom.wpr - 8'd1) begin
					cx_d = '0;
					if (cy_q == {1'b0, geom.rows} - 8'd1) begin
						state_d = ST_DONE;
					end else begin
						cy_d = cy_q + 8'd1;
					end
				end else begin
					cx_d = cx_q + 8'd1;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign init_busy = state_q == ST_INIT;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			init_q  <= '0;
		end else begin
			state_q <= state_d;
			init_q  <= init_d;
		end
	end

	// walker and command registers
	always_ff @(posedge clk) begin
		ph_q      <= ph_d;
		sub_q     <= sub_d;
		cx_q      <= cx_d;
		cy_q      <= cy_d;
		cmd_q     <= cmd_d;
		wr_addr_q <= wr_addr_d;
		bit_q     <= bit_d;
		value_q   <= value_d;
		oor_q     <= oor_d;
	end

	// frame store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			store_q[mem_waddr] <= mem_wdata;
		end
		rdata_q <= store_q[addr];
	end

	// result register, holds a transfer while the output is stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			pixel_value_q  <= value_q;
			out_of_range_q <= oor_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign pixel_value  = pixel_value_q;
	assign out_of_range = out_of_range_q;

endmodule

// ===== rtl/core/framebuffer_pixel_and_rect_engine.sv =====
// Frame buffer engine: plots, reads, outlines, fills and clears pixels in a
// store of MAX_ROWS*MAX_COLS 16-bit words, mono (16 pixels per word) or RGB565.
// After reset the store is zeroed by a sweep of all its words, during which
// in_stall stays high; configuration writes are taken at all times. Commands
// go through a two-entry queue to a back end that does one read-modify-write
// of one word per drawn pixel through the store's one write port. A set or
// get pixel passes through queue hand-off, address and read, modify and write,
// and result, and skips the modify step outside the frame, as do the pixels of
// an outline or filled rectangle; a clear zeroes each word of the visible area
// in turn. Every command returns exactly one result; a finished result waits
// in an output register while following commands are already accepted.
module framebuffer_pixel_and_rect_engine #(
	parameter int MAX_COLS = 128,
	parameter int MAX_ROWS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  func,
	input  logic [7:0]  x_first,
	input  logic [7:0]  y_first,
	input  logic [7:0]  x_second,
	input  logic [7:0]  y_second,
	input  logic [15:0] pen_color,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] pixel_value,
	output logic        out_of_range,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import fbpr_pkg::*;

	logic       pixel_mode_q;
	logic [7:0] columns_q;
	logic [6:0] rows_q;
	geom_t      geom;

	logic       q_ready;
	logic       q_push;
	cmd_t       q_cmd;
	logic       head_valid;
	cmd_t       head_cmd;
	logic       pop;
	logic       init_busy;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_mode_q <= MODE_RESET;
			columns_q    <= COLS_RESET;
			rows_q       <= ROWS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PIXEL_MODE: pixel_mode_q <= cfg_data[0];
				REG_COLUMNS:    columns_q    <= cfg_data;
				REG_ROWS:       rows_q       <= cfg_data[6:0];
				default:        ;
			endcase
		end
	end

	// effective geometry: clamped width and height, words per row
	always_comb begin
		geom.rgb = pixel_mode_q;
		if (columns_q == '0) begin
			geom.cols = 8'd1;
		end else if (int'(columns_q) > MAX_COLS) begin
			geom.cols = 8'(MAX_COLS);
		end else begin
			geom.cols = columns_q;
		end
		if (rows_q == '0) begin
			geom.rows = 7'd1;
		end else if (int'(rows_q) > MAX_ROWS) begin
			geom.rows = 7'(MAX_ROWS);
		end else begin
			geom.rows = rows_q;
		end
		if (pixel_mode_q) begin
			geom.wpr = geom.cols;
		end else if (geom.cols[7:4] == '0) begin
			geom.wpr = 8'd1;
		end else begin
			geom.wpr = {4'd0, geom.cols[7:4]};
		end
	end

	fbpr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.hold      (init_busy),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func),
		.x_first   (x_first),
		.y_first   (y_first),
		.x_second  (x_second),
		.y_second  (y_second),
		.pen_color (pen_color),
		.q_ready   (q_ready),
		.q_push    (q_push),
		.q_cmd     (q_cmd)
	);

	fbpr_cmd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_cmd   (q_cmd),
		.push_ready (q_ready),
		.pop        (pop),
		.head_cmd   (head_cmd),
		.head_valid (head_valid)
	);

	fbpr_back #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.geom         (geom),
		.head_valid   (head_valid),
		.head_cmd     (head_cmd),
		.pop          (pop),
		.init_busy    (init_busy),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pixel_value  (pixel_value),
		.out_of_range (out_of_range)
	);

endmodule
